### rtl/twa_pkg.sv
// ----------------------------------------------------------------------------
// twa_pkg
// Shared constants and control types of the tumbling window averager.
// ----------------------------------------------------------------------------
package twa_pkg;

  localparam int TIME_W      = 48;
  localparam int VALUE_W     = 32;
  localparam int MAX_SAMPLES = 65535;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  // sum of MAX_SAMPLES values of VALUE_W bits always fits, no saturation needed
  localparam int SUM_W       = VALUE_W + CNT_W;
  localparam int SHIFT_W     = 6;
  localparam int SHIFT_LIMIT = 40;
  localparam int RESET_SHIFT = 20;
  localparam int EFF_LIMIT   = (SHIFT_LIMIT < TIME_W - 1) ? SHIFT_LIMIT : TIME_W - 1;
  localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_DIVIDE,
    KIND_PUSH
  } item_kind_t;

  typedef struct packed {
    logic accept;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    item_kind_t kind;
    logic       div_done;
    logic       out_free;
  } dp_status_t;

endpackage

### rtl/twa_ifs.sv
// ----------------------------------------------------------------------------
// twa_ifs
// Valid/ready channels of the tumbling window averager: sample input and
// window result output.
// ----------------------------------------------------------------------------
interface twa_in_if
  import twa_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [TIME_W-1:0]         timestamp;
  logic signed [VALUE_W-1:0] sample_value;

  modport source (output valid, output operation, output timestamp,
                  output sample_value, input ready);
  modport sink   (input valid, input operation, input timestamp,
                  input sample_value, output ready);
endinterface

interface twa_out_if
  import twa_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [TIME_W-1:0]         window_end;
  logic signed [VALUE_W-1:0] average;
  logic [CNT_W-1:0]          sample_total;
  logic                      out_of_order;
  logic                      overflowed;

  modport source (output valid, output window_end, output average,
                  output sample_total, output out_of_order, output overflowed,
                  input ready);
  modport sink   (input valid, input window_end, input average,
                  input sample_total, input out_of_order, input overflowed,
                  output ready);
endinterface

### rtl/twa_divider.sv
// ----------------------------------------------------------------------------
// twa_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twa_divider
  import twa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [SUM_W-1:0] quotient,
  output logic             done
);

  logic [SUM_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W+1:0]     diff;

  // remainder stays below the divisor, so it always fits in CNT_W bits
  always_comb begin
    rem_sh = {rem_r, quo_r[SUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
    if (!diff[CNT_W+1]) begin
      rem_nxt = diff[CNT_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[CNT_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held longer than one cycle");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still busy");

endmodule

### rtl/twa_datapath.sv
// ----------------------------------------------------------------------------
// twa_datapath
// Window state, item decode, result staging, divider and output register.
// ----------------------------------------------------------------------------
module twa_datapath
  import twa_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [SHIFT_W-1:0]        cfg_wdata,
  input  logic                      in_operation,
  input  logic [TIME_W-1:0]         in_timestamp,
  input  logic signed [VALUE_W-1:0] in_sample_value,
  input  logic                      out_ready,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status,
  output logic                      out_valid,
  output logic [TIME_W-1:0]         out_window_end,
  output logic signed [VALUE_W-1:0] out_average,
  output logic [CNT_W-1:0]          out_sample_total,
  output logic                      out_out_of_order,
  output logic                      out_overflowed
);

  logic [SHIFT_W-1:0]      shift_r;
  logic [TIME_W-1:0]       win_end_r, win_end_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [TIME_W-1:0]       last_r, last_nxt;
  logic                    ovf_r, ovf_nxt;

  logic [TIME_W-1:0]       stg_end_r;
  logic [CNT_W-1:0]        stg_cnt_r;
  logic                    stg_ovf_r, stg_ooo_r, stg_neg_r;

  logic                    out_valid_r;
  logic [TIME_W-1:0]       out_end_r;
  logic [VALUE_W-1:0]      out_avg_r;
  logic [CNT_W-1:0]        out_cnt_r;
  logic                    out_ooo_r, out_ovf_r;

  logic [SHIFT_W-1:0]      eff_shift;
  logic [TIME_W-1:0]       unit, base;
  logic [TIME_W:0]         end_sum;
  logic [TIME_W-1:0]       new_end;
  logic                    is_ooo, closes, has_samples;
  item_kind_t              kind;
  logic [SUM_W-1:0]        v_ext, sum_mag, quo;
  logic [VALUE_W-1:0]      avg_mag, avg_signed;
  logic                    start_div, div_done;

  always_comb begin
    eff_shift = (shift_r > SHIFT_W'(EFF_LIMIT)) ? SHIFT_W'(EFF_LIMIT) : shift_r;
    unit      = TIME_W'(1) << eff_shift;
    base      = in_timestamp & ~(unit - TIME_W'(1));
    end_sum   = {1'b0, base} + {1'b0, unit};
    // end past the time range saturates
    new_end   = end_sum[TIME_W] ? {TIME_W{1'b1}} : end_sum[TIME_W-1:0];

    has_samples = (cnt_r != '0);
    is_ooo      = !in_operation && (in_timestamp < last_r);
    closes      = !in_operation && !is_ooo && (in_timestamp >= win_end_r);

    if (is_ooo) begin
      kind = KIND_PUSH;
    end else if ((in_operation || closes) && has_samples) begin
      kind = KIND_DIVIDE;
    end else begin
      kind = KIND_NONE;
    end

    v_ext   = {{(SUM_W-VALUE_W){in_sample_value[VALUE_W-1]}}, in_sample_value};
    sum_mag = sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;

    win_end_nxt = win_end_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    last_nxt    = last_r;
    ovf_nxt     = ovf_r;
    if (in_operation) begin
      sum_nxt = '0;
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (!is_ooo) begin
      last_nxt = in_timestamp;
      if (closes) begin
        win_end_nxt = new_end;
        sum_nxt     = v_ext;
        cnt_nxt     = CNT_W'(1);
        ovf_nxt     = 1'b0;
      end else if (cnt_r >= CNT_W'(MAX_SAMPLES)) begin
        ovf_nxt = 1'b1;
      end else begin
        sum_nxt = sum_r + v_ext;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  assign start_div = cmd.accept && (kind == KIND_DIVIDE);

  twa_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_div),
    .dividend (sum_mag),
    .divisor  (cnt_r),
    .quotient (quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r   <= SHIFT_W'(RESET_SHIFT);
      win_end_r <= TIME_W'(1) << RESET_SHIFT;
      sum_r     <= '0;
      cnt_r     <= '0;
      last_r    <= '0;
      ovf_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        shift_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        win_end_r <= win_end_nxt;
        sum_r     <= sum_nxt;
        cnt_r     <= cnt_nxt;
        last_r    <= last_nxt;
        ovf_r     <= ovf_nxt;
      end
    end
  end

  // snapshot of the window being closed (zeroed for a dropped out-of-order sample), taken before the state moves on
  always_ff @(posedge clk) begin
    if (cmd.accept && (kind != KIND_NONE)) begin
      stg_end_r <= is_ooo ? '0 : win_end_r;
      stg_cnt_r <= is_ooo ? '0 : cnt_r;
      stg_ovf_r <= is_ooo ? 1'b0 : ovf_r;
      stg_ooo_r <= is_ooo;
      stg_neg_r <= sum_r[SUM_W-1];
    end
  end

  always_comb begin
    avg_mag    = quo[VALUE_W-1:0];
    avg_signed = stg_neg_r ? (~avg_mag + VALUE_W'(1)) : avg_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_end_r <= stg_end_r;
      out_avg_r <= stg_ooo_r ? '0 : avg_signed;
      out_cnt_r <= stg_cnt_r;
      out_ooo_r <= stg_ooo_r;
      out_ovf_r <= stg_ovf_r;
    end
  end

  assign status.kind     = kind;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_window_end   = out_end_r;
  assign out_average      = out_avg_r;
  assign out_sample_total = out_cnt_r;
  assign out_out_of_order = out_ooo_r;
  assign out_overflowed   = out_ovf_r;

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SAMPLES)) else $error("sample count past limit");
  a_ooo_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ooo_r) |-> (out_cnt_r == '0 && !out_ovf_r))
    else $error("out-of-order result carries window data");
  a_ooo_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && is_ooo) |=> $stable(last_r) && $stable(cnt_r))
    else $error("out-of-order sample changed window state");

endmodule

### rtl/twa_ctrl.sv
// ----------------------------------------------------------------------------
// twa_ctrl
// Controller: accepts requests, sequences the divider and the result push.
// ----------------------------------------------------------------------------
module twa_ctrl
  import twa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  assign cmd.accept   = in_valid && in_ready_r;
  assign cmd.load_out = (state_r == ST_PUSH) && status.out_free;
  assign in_ready     = in_ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cmd.accept && status.kind == KIND_DIVIDE) begin
            state_r    <= ST_DIV;
            in_ready_r <= 1'b0;
          end else if (cmd.accept && status.kind == KIND_PUSH) begin
            state_r    <= ST_PUSH;
            in_ready_r <= 1'b0;
          end
        end
        ST_DIV: begin
          if (status.div_done) begin
            state_r <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (status.out_free) begin
            state_r    <= ST_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> (state_r == ST_IDLE)) else $error("ready outside idle");
  a_div_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && status.kind == KIND_DIVIDE) |=> (state_r == ST_DIV && !in_ready_r))
    else $error("window close did not start division");
  a_push_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (state_r == ST_IDLE && in_ready_r))
    else $error("controller did not return to idle after push");

endmodule

### rtl/tumbling_window_averager_top.sv
// ----------------------------------------------------------------------------
// tumbling_window_averager_top
// Averages timestamped samples over windows of one whole time unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries requests: operation 0 = sample, 1 = flush the open window.
//   out_ch carries one result per closed non-empty window or per dropped
//   out-of-order sample. cfg_we/cfg_wdata write window_shift (reset 20);
//   write it only while the block is idle.
//   A sample inside the open window gives no result; such samples
//   stream at one per cycle while in_ready is high.
//   A request that closes a non-empty window starts the shift-subtract
//   divider, one quotient bit per cycle; in_ready stays low through the
//   division and the result push, until the output register is free.
//   An out-of-order sample blocks input until its result has been pushed
//   through the staging register into the output register.
//   The result waits in the output register while out_ch stalls; samples
//   that add to the window keep being taken meanwhile, a request that
//   needs a new result holds in_ready low until the register is free.
//   Reset (rst_n low, synchronous) empties the window, sets its end to one
//   time unit and drops any pending result.
// ----------------------------------------------------------------------------
module tumbling_window_averager_top
  import twa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  twa_in_if.sink             in_ch,
  twa_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [SHIFT_W-1:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  twa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  twa_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_operation     (in_ch.operation),
    .in_timestamp     (in_ch.timestamp),
    .in_sample_value  (in_ch.sample_value),
    .out_ready        (out_ch.ready),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_ch.valid),
    .out_window_end   (out_ch.window_end),
    .out_average      (out_ch.average),
    .out_sample_total (out_ch.sample_total),
    .out_out_of_order (out_ch.out_of_order),
    .out_overflowed   (out_ch.overflowed)
  );

endmodule

### sim/tb_tumbling_window_averager_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tumbling_window_averager_top
// Self-checking bench for the tumbling window averager. A directed table and
// randomized phases at several window shifts drive requests through the input
// channel. A cycle-free predictor computes the window results, which are
// compared field by field with the output channel. Both channels idle at
// random, the result side holds off once for a long stretch, and the window
// end is driven to the top of the time range.
// ----------------------------------------------------------------------------
module tb_tumbling_window_averager_top;
  import twa_pkg::*;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  localparam int          SETTLE_CYCLES = 80;  // divider plus result push, with margin
  localparam int          LONG_HOLD     = 400;
  localparam int          PHASE_ITEMS   = 135;
  localparam int          RUN_LIMIT_NS  = 15_000_000;
  localparam logic [63:0] TIME_MAX      = (64'd1 << TIME_W) - 1;
  // random time stays below this so the top of the range is left for the end
  localparam logic [63:0] TIME_CEIL     = 64'h0000_C000_0000_0000;
  localparam longint      AVG_HI        = (longint'(1) << (VALUE_W - 1)) - 1;
  localparam longint      AVG_LO        = -AVG_HI - 1;

  typedef struct packed {
    logic [TIME_W-1:0]         window_end;
    logic signed [VALUE_W-1:0] average;
    logic [CNT_W-1:0]          sample_total;
    logic                      out_of_order;
    logic                      overflowed;
  } window_result_t;

  // low two bits are out_of_order, overflowed
  localparam window_result_t DROPPED_RESULT = window_result_t'(2'b10);

  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NONE,
    CHK_GIVEN
  } check_t;

  typedef enum logic [1:0] {
    SINK_STEADY,
    SINK_SPOTTY,
    SINK_SLUGGISH
  } sink_mode_t;

  typedef struct {
    logic                      op;
    logic [TIME_W-1:0]         ts;
    logic signed [VALUE_W-1:0] val;
    check_t                    chk;
    window_result_t            given;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [SHIFT_W-1:0] cfg_wdata;

  always #6 clk = ~clk;

  twa_in_if  in_if ();
  twa_out_if out_if ();

  tumbling_window_averager_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the block state
  logic [SHIFT_W-1:0] shadow_shift;
  logic [TIME_W-1:0]  open_end;
  longint             open_sum;  // cannot leave 48 bits, no saturation needed
  int unsigned        open_count;
  logic [TIME_W-1:0]  newest_ts;
  bit                 open_overflow;

  window_result_t window_results[$];
  plan_row_t      plan[$];

  int  error_count;
  int  requests_sent;
  int  flushes_sent;
  int  dropped_seen;
  int  results_checked;
  int  shifts_written;
  int  long_holds_asked;
  int  burst_left;
  bit  gaps_on;

  function automatic window_result_t close_summary();
    window_result_t res;
    longint avg;
    avg = open_sum / longint'(open_count);
    if (avg > AVG_HI) avg = AVG_HI;
    if (avg < AVG_LO) avg = AVG_LO;
    res.window_end   = open_end;
    res.average      = avg[VALUE_W-1:0];
    res.sample_total = open_count[CNT_W-1:0];
    res.out_of_order = 1'b0;
    res.overflowed   = open_overflow;
    return res;
  endfunction

  function automatic bit predict_window(input logic op, input logic [TIME_W-1:0] ts,
                                        input logic signed [VALUE_W-1:0] val,
                                        output window_result_t res);
    logic [63:0] unit_len;
    logic [63:0] base;
    logic [63:0] new_end;
    int unsigned eff;
    bit          emitted;
    res = '0;
    emitted = 1'b0;
    if (op == OP_FLUSH) begin
      if (open_count > 0) begin
        res = close_summary();
        emitted = 1'b1;
      end
      open_sum = 0;
      open_count = 0;
      open_overflow = 1'b0;
      return emitted;
    end
    if (ts < newest_ts) begin
      res = DROPPED_RESULT;
      return 1'b1;
    end
    newest_ts = ts;
    if (ts < open_end) begin
      if (open_count >= MAX_SAMPLES) begin
        open_overflow = 1'b1;
      end else begin
        open_sum = open_sum + longint'(val);
        open_count++;
      end
      return 1'b0;
    end
    if (open_count > 0) begin
      res = close_summary();
      emitted = 1'b1;
    end
    eff = (shadow_shift > EFF_LIMIT) ? EFF_LIMIT : shadow_shift;
    unit_len = 64'd1 << eff;
    base = 64'(ts) & ~(unit_len - 1);
    new_end = base + unit_len;
    open_end = (new_end > TIME_MAX) ? TIME_MAX[TIME_W-1:0] : new_end[TIME_W-1:0];
    open_sum = longint'(val);
    open_count = 1;
    open_overflow = 1'b0;
    return emitted;
  endfunction

  function automatic logic [63:0] rand_below(input logic [63:0] n);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return (n == 0) ? 64'd0 : r % n;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return AVG_HI[VALUE_W-1:0];
      1:       return AVG_LO[VALUE_W-1:0];
      2, 3:    return VALUE_W'($signed($urandom_range(0, 200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input logic op, input logic [TIME_W-1:0] ts,
                         input logic signed [VALUE_W-1:0] val, input check_t chk,
                         input window_result_t given);
    plan_row_t row;
    row.op = op;
    row.ts = ts;
    row.val = val;
    row.chk = chk;
    row.given = given;
    plan.push_back(row);
  endtask

  // Offers one request, waits for the handshake, records what it should cause.
  task automatic offer_request(input logic op, input logic [TIME_W-1:0] ts,
                               input logic signed [VALUE_W-1:0] val,
                               input check_t chk, input window_result_t given);
    window_result_t res;
    bit             has_res;
    int             gap;
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.operation    <= op;
    in_if.timestamp    <= ts;
    in_if.sample_value <= val;
    do @(posedge clk); while (!in_if.ready);
    has_res = predict_window(op, ts, val, res);
    requests_sent++;
    if (op == OP_FLUSH) flushes_sent++;
    if (has_res && res.out_of_order) dropped_seen++;
    case (chk)
      CHK_PREDICT: if (has_res) window_results.push_back(res);
      CHK_GIVEN:   window_results.push_back(given);
      default:     ;
    endcase
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(1, 8);
        @(negedge clk);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(0, 25);
      end
    end
  endtask

  // Stops offering, lets every expected result drain, then lets the block go idle.
  task automatic settle_block();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (window_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_shift(input logic [SHIFT_W-1:0] value);
    settle_block();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    shadow_shift = value;
    shifts_written++;
  endtask

  task automatic run_random_phase(input int n_items, input bit with_hold);
    logic [63:0]       unit_len;
    logic [63:0]       step;
    logic [TIME_W-1:0] ts;
    int unsigned       eff;
    int                pick;
    int                sel;
    eff = (shadow_shift > EFF_LIMIT) ? EFF_LIMIT : shadow_shift;
    unit_len = 64'd1 << eff;
    for (int i = 0; i < n_items; i++) begin
      if (with_hold && i == n_items / 3) long_holds_asked++;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // timestamp and value ride along on a flush but must be ignored
        offer_request(OP_FLUSH, TIME_W'({$urandom, $urandom}), $urandom,
                      CHK_PREDICT, '0);
      end else if (pick < 10 && newest_ts != 0) begin
        ts = TIME_W'(rand_below(64'(newest_ts)));
        offer_request(OP_SAMPLE, ts, pick_value(), CHK_PREDICT, '0);
      end else begin
        sel = $urandom_range(0, 19);
        if (sel == 0)
          step = 0;
        else if (sel < 14)
          step = rand_below(unit_len >> 3);
        else if (sel < 19)
          step = unit_len * $urandom_range(1, 3) + rand_below(unit_len);
        else
          step = unit_len * $urandom_range(4, 12) + rand_below(unit_len);
        if (64'(newest_ts) + step > TIME_CEIL) step = 0;
        ts = newest_ts + step[TIME_W-1:0];
        offer_request(OP_SAMPLE, ts, pick_value(), CHK_PREDICT, '0);
      end
    end
  endtask

  // result side: own stall pattern, plus long hold-offs on request
  initial begin : result_sink
    int         mode_left;
    int         hold_left;
    int         holds_served;
    sink_mode_t mode;
    out_if.ready = 1'b0;
    mode_left = 0;
    hold_left = 0;
    holds_served = 0;
    mode = SINK_STEADY;
    forever begin
      @(negedge clk);
      if (holds_served != long_holds_asked) begin
        holds_served = long_holds_asked;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          SINK_STEADY: out_if.ready <= 1'b1;
          SINK_SPOTTY: out_if.ready <= ($urandom_range(0, 9) < 7);
          default:     out_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    window_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_checked++;
      if (window_results.size() == 0) begin
        $error("result with none expected: window_end %0h average %0d",
               out_if.window_end, out_if.average);
        error_count++;
      end else begin
        want = window_results.pop_front();
        if (out_if.window_end !== want.window_end) begin
          $error("window_end: expected %0h, got %0h", want.window_end, out_if.window_end);
          error_count++;
        end
        if (out_if.average !== want.average) begin
          $error("average: expected %0d, got %0d", want.average, out_if.average);
          error_count++;
        end
        if (out_if.sample_total !== want.sample_total) begin
          $error("sample_total: expected %0d, got %0d",
                 want.sample_total, out_if.sample_total);
          error_count++;
        end
        if (out_if.out_of_order !== want.out_of_order) begin
          $error("out_of_order: expected %0b, got %0b",
                 want.out_of_order, out_if.out_of_order);
          error_count++;
        end
        if (out_if.overflowed !== want.overflowed) begin
          $error("overflowed: expected %0b, got %0b", want.overflowed, out_if.overflowed);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("tb_tumbling_window_averager_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.operation    = OP_SAMPLE;
    in_if.timestamp    = '0;
    in_if.sample_value = '0;
    error_count = 0;
    requests_sent = 0;
    flushes_sent = 0;
    dropped_seen = 0;
    results_checked = 0;
    shifts_written = 0;
    long_holds_asked = 0;
    burst_left = 0;
    gaps_on = 1'b1;

    shadow_shift  = RESET_SHIFT;
    open_end      = TIME_W'(64'd1 << RESET_SHIFT);
    open_sum      = 0;
    open_count    = 0;
    newest_ts     = '0;
    open_overflow = 1'b0;

    // directed part at the reset shift: one time unit is 0x10_0000
    add_row(OP_FLUSH,  48'hFFFF_FFFF_FFFF, 32'sh1234_5678, CHK_NONE, '0);
    add_row(OP_SAMPLE, 48'h0,         32'sh7FFF_FFFF, CHK_PREDICT, '0);
    add_row(OP_SAMPLE, 48'h0,         32'sh7FFF_FFFF, CHK_PREDICT, '0);
    add_row(OP_SAMPLE, 48'h0F_FFFF,   32'sh0000_0001, CHK_PREDICT, '0);
    add_row(OP_SAMPLE, 48'h10_0000,   32'sh8000_0000, CHK_GIVEN,
            {48'h10_0000, 32'h5555_5555, 16'd3, 1'b0, 1'b0});
    add_row(OP_SAMPLE, 48'h10_0000,   32'shFFFF_FFFF, CHK_PREDICT, '0);
    add_row(OP_SAMPLE, 48'h1F_FFFF,   32'sh0000_0000, CHK_PREDICT, '0);
    add_row(OP_SAMPLE, 48'h0F_FFFF,   32'shAAAA_AAAA, CHK_GIVEN, DROPPED_RESULT);
    add_row(OP_FLUSH,  48'h0,         32'sh0000_0000, CHK_PREDICT, '0);
    add_row(OP_FLUSH,  48'h0,         32'sh0000_0000, CHK_NONE, '0);
    add_row(OP_SAMPLE, 48'h1F_FFFF,   -32'sd7,        CHK_PREDICT, '0);
    add_row(OP_SAMPLE, 48'h1F_FFFF,   32'sd2,         CHK_PREDICT, '0);
    add_row(OP_SAMPLE, 48'h50_1234,   32'sh5555_5555, CHK_PREDICT, '0);
    add_row(OP_SAMPLE, 48'h5F_FFFF,   32'shAAAA_AAAA, CHK_PREDICT, '0);
    add_row(OP_SAMPLE, 48'h60_0000,   32'sd3,         CHK_PREDICT, '0);
    add_row(OP_SAMPLE, 48'h0,         32'shFFFF_FFFF, CHK_GIVEN, DROPPED_RESULT);
    add_row(OP_SAMPLE, 48'h60_0000,   32'sd100,       CHK_PREDICT, '0);
    add_row(OP_FLUSH,  48'h0,         32'sh0000_0000, CHK_PREDICT, '0);
    add_row(OP_SAMPLE, 48'h60_0001,   32'sd5,         CHK_PREDICT, '0);
    add_row(OP_SAMPLE, 48'h70_0000,   32'sd6,         CHK_PREDICT, '0);
    add_row(OP_FLUSH,  48'h0,         32'sh0000_0000, CHK_PREDICT, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i])
      offer_request(plan[i].op, plan[i].ts, plan[i].val, plan[i].chk, plan[i].given);

    write_shift(6'd0);
    run_random_phase(PHASE_ITEMS, 1'b0);
    write_shift(6'd20);
    run_random_phase(PHASE_ITEMS, 1'b1);
    write_shift(6'd41);  // clamps to the shift limit
    run_random_phase(PHASE_ITEMS, 1'b0);
    write_shift(SHIFT_W'($urandom_range(1, 39)));
    run_random_phase(PHASE_ITEMS, 1'b0);
    write_shift(6'd7);
    run_random_phase(PHASE_ITEMS, 1'b0);
    write_shift(6'd33);
    run_random_phase(PHASE_ITEMS, 1'b0);

    // top of the time range, window end saturates
    write_shift(6'd63);
    offer_request(OP_SAMPLE, 48'hFEFF_FFFF_FFFF, pick_value(), CHK_PREDICT, '0);
    offer_request(OP_SAMPLE, 48'hFF00_0000_0000, pick_value(), CHK_PREDICT, '0);
    offer_request(OP_SAMPLE, 48'hFFFF_FFFF_FFFE, pick_value(), CHK_PREDICT, '0);
    offer_request(OP_SAMPLE, 48'hFFFF_FFFF_FFFF, pick_value(), CHK_PREDICT, '0);
    offer_request(OP_SAMPLE, 48'hFFFF_FFFF_FFFF, pick_value(), CHK_PREDICT, '0);
    offer_request(OP_SAMPLE, 48'h7FFF_FFFF_FFFF, pick_value(), CHK_PREDICT, '0);
    offer_request(OP_FLUSH,  48'h0, 32'sh0, CHK_PREDICT, '0);

    settle_block();
    $display("Run covered %0d requests (%0d flushes, %0d dropped out of order), %0d results.",
             requests_sent, flushes_sent, dropped_seen, results_checked);
    $display("%0d shift writes incl. 0, 41 and 63; window end saturation at the top of time.",
             shifts_written);
    if (error_count == 0)
      $display("tb_tumbling_window_averager_top: PASS");
    else
      $display("tb_tumbling_window_averager_top: FAIL");
    $finish;
  end

endmodule

### sim.f
rtl/twa_pkg.sv
rtl/twa_ifs.sv
rtl/twa_divider.sv
rtl/twa_datapath.sv
rtl/twa_ctrl.sv
rtl/tumbling_window_averager_top.sv
sim/tb_tumbling_window_averager_top.sv
